### sv/kdt_pkg.sv
package kdt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_W     = 5;
    localparam int KEY_W       = 24;
    localparam int ROUTE_W     = 24;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        op_t                opcode;
        logic [7:0]         dev_no_low;
        logic [7:0]         dev_no_high;
        logic [7:0]         dev_type;
        logic [ROUTE_W-1:0] main_route_in;
        logic [ROUTE_W-1:0] backup_route_in;
    } cmd_t;

    typedef struct packed {
        logic                  success;
        logic                  found;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [COUNT_W-1:0]    entries_used;
        logic [ROUTE_W-1:0]    main_route_out;
        logic [ROUTE_W-1:0]    backup_route_out;
    } rsp_t;

endpackage

### sv/kdt_ram.sv
module kdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/keyed_device_table.sv
// Keyed device table: a table of device entries, each keyed by a 16-bit device
// number and an 8-bit type, holding a main and a backup route.
// A command beat is taken at a rising edge where start is high and busy is low.
// Lookup, add and delete scan the key memory from slot zero, one slot per cycle,
// and stop at the first valid match; the scan is pipelined behind the registered
// read of the key memory, and a command ends early on a match.
// Clear skips the scan. Busy stays high until the result is issued.
// Each command gives exactly one result beat on rsp, marked by done for one cycle.
// The receiver cannot hold results off, and none is needed: at most one result is
// ever pending, and it is issued in the cycle that busy falls.
// Reset clears all valid bits and the entry count; keys and routes in the two
// memories are written by add before they are ever used, so they need no clearing.
module keyed_device_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  kdt_pkg::cmd_t  cmd,
    output logic           done,
    output kdt_pkg::rsp_t  rsp
);
    import kdt_pkg::*;

    state_t                  state_reg;
    state_t                  state_next;
    cmd_t                    cmd_reg;
    logic [TABLE_DEPTH-1:0]  valid_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [COUNT_W-1:0]      count_next;
    logic [SLOT_W-1:0]       scan_idx_reg;
    logic [SLOT_W-1:0]       cmp_idx_reg;
    logic                    cmp_vld_reg;
    logic                    hit_reg;
    logic [SLOT_W-1:0]       hit_idx_reg;
    logic                    free_found_reg;
    logic [SLOT_W-1:0]       free_idx_reg;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;
    logic                    done_reg;

    logic                    accept;
    logic [KEY_W-1:0]        key;
    logic [KEY_W-1:0]        key_rdata;
    logic [2*ROUTE_W-1:0]    route_rdata;
    logic                    hit_now;
    logic                    free_now;
    logic                    scan_end;
    logic                    add_write;
    logic                    del_clear;

    assign key    = {cmd_reg.dev_type, cmd_reg.dev_no_high, cmd_reg.dev_no_low};
    assign accept = start && (state_reg == ST_IDLE);

    kdt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (add_write),
        .waddr (free_idx_reg),
        .wdata (key),
        .raddr (scan_idx_reg),
        .rdata (key_rdata)
    );

    kdt_ram #(
        .WIDTH (2 * ROUTE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_route_ram (
        .clk   (clk),
        .we    (add_write),
        .waddr (free_idx_reg),
        .wdata ({cmd_reg.main_route_in, cmd_reg.backup_route_in}),
        .raddr (cmp_idx_reg),
        .rdata (route_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd.opcode == OP_CLEAR) ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit_now || scan_end)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        hit_now   = 1'b0;
        free_now  = 1'b0;
        scan_end  = 1'b0;
        add_write = 1'b0;
        del_clear = 1'b0;
        count_next = count_reg;
        rsp_next  = '0;
        rsp_next.success = 1'b1;
        case (state_reg)
            ST_SCAN:
            begin
                hit_now  = cmp_vld_reg && valid_reg[cmp_idx_reg] && (key_rdata == key);
                free_now = cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_found_reg;
                scan_end = cmp_vld_reg && (cmp_idx_reg == LAST_SLOT);
            end
            ST_RESP:
            begin
                case (cmd_reg.opcode)
                    OP_LOOKUP:
                    begin
                        rsp_next.found = hit_reg;
                        if (hit_reg)
                        begin
                            rsp_next.slot_index       = SLOT_OUT_W'(hit_idx_reg);
                            rsp_next.main_route_out   = route_rdata[2*ROUTE_W-1:ROUTE_W];
                            rsp_next.backup_route_out = route_rdata[ROUTE_W-1:0];
                        end
                    end
                    OP_ADD:
                    begin
                        rsp_next.found = hit_reg;
                        if (hit_reg)
                        begin
                            rsp_next.slot_index = SLOT_OUT_W'(hit_idx_reg);
                        end
                        else if (free_found_reg)
                        begin
                            add_write           = 1'b1;
                            count_next          = count_reg + COUNT_W'(1);
                            rsp_next.slot_index = SLOT_OUT_W'(free_idx_reg);
                        end
                        else
                        begin
                            rsp_next.success = 1'b0;
                        end
                    end
                    OP_DELETE:
                    begin
                        rsp_next.found = hit_reg;
                        if (hit_reg)
                        begin
                            del_clear           = 1'b1;
                            count_next          = count_reg - COUNT_W'(1);
                            rsp_next.slot_index = SLOT_OUT_W'(hit_idx_reg);
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                rsp_next.entries_used = count_next;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_RESP);
            count_reg <= count_next;
            if (accept)
            begin
                scan_idx_reg   <= '0;
                cmp_vld_reg    <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (state_reg == ST_SCAN)
            begin
                cmp_idx_reg <= scan_idx_reg;
                cmp_vld_reg <= 1'b1;
                if (scan_idx_reg != LAST_SLOT)
                begin
                    scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                end
                if (hit_now)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= cmp_idx_reg;
                end
                if (free_now)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end
            if (state_reg == ST_RESP)
            begin
                if (cmd_reg.opcode == OP_CLEAR)
                begin
                    valid_reg <= '0;
                end
                else if (add_write)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                else if (del_clear)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_RESP)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == COUNT_W'($countones(valid_reg)))
        else $error("Entry count disagrees with the valid bits.");

    a_done_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_RESP) && !busy)
        else $error("Result beat without a response cycle.");

    a_write_only_to_free: assert property (@(posedge clk) disable iff (!rst_n)
        add_write |-> !valid_reg[free_idx_reg] && !hit_reg)
        else $error("Add writes over a valid entry.");

    a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && hit_now) |=> state_reg == ST_RESP && hit_reg)
        else $error("Scan continued past a match.");
`endif

endmodule
